// ===== src/telneg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telneg_pkg : shared types and constants for the Telnet receive negotiator
// Command codes, option numbers, parser states, result kinds and the job
// record passed from the parser to the reply sequencer.
// ---------------------------------------------------------------------------
package telneg_pkg;

  // Telnet command bytes
  localparam logic [7:0] C_SE   = 8'd240;
  localparam logic [7:0] C_AYT  = 8'd246;
  localparam logic [7:0] C_EC   = 8'd247;
  localparam logic [7:0] C_SB   = 8'd250;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_DO   = 8'd253;
  localparam logic [7:0] C_DONT = 8'd254;
  localparam logic [7:0] C_IAC  = 8'd255;

  localparam logic [7:0] TELOPT_ECHO = 8'd1;
  localparam logic [7:0] TELOPT_SGA  = 8'd3;
  localparam logic [7:0] BACKSPACE   = 8'd8;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_AYT   = 2'd2;

  typedef enum logic [3:0] {
    ST_CMD   = 4'd0,
    ST_TYPE  = 4'd1,
    ST_SBOPT = 4'd2,
    ST_SBVAL = 4'd3,
    ST_SE    = 4'd4,
    ST_DO    = 4'd5,
    ST_DONT  = 4'd6,
    ST_WILL  = 4'd7,
    ST_WONT  = 4'd8,
    ST_SBIAC = 4'd9
  } parse_state_t;

  // One queued job: either a single result, or a three-beat reply IAC cmd opt
  typedef struct packed {
    logic       is_reply;
    logic [1:0] kind;
    logic [7:0] val_a;   // data value, or reply command
    logic [7:0] val_b;   // reply option
    logic       echo;
    logic       sga;
  } job_t;

endpackage

// ===== src/telnet_rx_option_negotiator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telnet_rx_option_negotiator : Telnet receive command parser, top level
// Strips IAC sequences from received bytes and answers option requests.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one received byte per beat; s_axis_tuser set means
//   "new connection" - parser and option flags clear, the byte is dropped.
//   Master stream m_axis_*: results. m_axis_tuser is the kind (data byte for
//   the application, reply byte to the peer, are-you-there event);
//   m_axis_tlast marks the last result caused by one input byte.
//   Echo and suppress-go-ahead flags ride along on every result beat.
// Timing:
//   A byte is accepted every cycle while the job queue has room. Its first
//   result beat is written into the job queue on acceptance, then loaded into
//   the output register once that is free. Data bytes stream out at one beat per
//   cycle while m_axis_tready is high; an option reply is three beats (IAC cmd opt)
//   drained by the output sequencer, so sustained rate is one byte per cycle
//   unless replies pile up faster than the sequencer drains them and fill the queue.
// Stalls and reset:
//   If m_axis_tready stays low the output register holds, the queue fills
//   and s_axis_tready drops when it is full. rst empties everything and
//   returns the parser to normal mode with both flags clear.
// ---------------------------------------------------------------------------
module telnet_rx_option_negotiator
  import telneg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] session_reset
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value, [8] echo_on, [9] suppress_ga_on
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);

  logic       in_fire;
  logic       push, q_ready, pop, head_valid;
  job_t       new_job, head_job;
  logic [7:0] value;
  logic       echo_on, suppress_ga_on;

  assign s_axis_tready = q_ready;
  assign in_fire       = s_axis_tvalid & q_ready;

  // front: parse and classify, one byte per cycle while the queue has room
  telneg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .rx_byte       (s_axis_tdata),
    .session_reset (s_axis_tuser),
    .push          (push),
    .job           (new_job)
  );

  // job queue decouples parser from output stalls
  telneg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (new_job),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: expand jobs into result beats
  telneg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_value  (value),
    .out_last   (m_axis_tlast),
    .out_echo   (echo_on),
    .out_sga    (suppress_ga_on)
  );

  assign m_axis_tdata = {6'd0, suppress_ga_on, echo_on, value};

endmodule

// ===== src/telneg_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telneg_front : Telnet command parser and option flag keeper
// Classifies each received byte combinationally and emits at most one job.
// ---------------------------------------------------------------------------
module telneg_front
  import telneg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  input  logic       session_reset,
  output logic       push,
  output job_t       job
);

  parse_state_t state, state_next;
  logic         echo, echo_next;
  logic         sga, sga_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CMD;
      echo  <= 1'b0;
      sga   <= 1'b0;
    end else begin
      state <= state_next;
      echo  <= echo_next;
      sga   <= sga_next;
    end
  end

  always_comb begin
    parse_state_t cmd_state;
    logic         cmd_push;
    logic [1:0]   cmd_kind;
    logic [7:0]   cmd_val;
    logic         is_echo;
    logic         is_sga;
    logic         opt_flag;

    // command byte after IAC
    cmd_state = ST_CMD;
    cmd_push  = 1'b0;
    cmd_kind  = KIND_DATA;
    cmd_val   = 8'd0;
    unique case (rx_byte)
      C_IAC:  begin cmd_push = 1'b1; cmd_val = C_IAC; end
      C_SB:   cmd_state = ST_SBOPT;
      C_DO:   cmd_state = ST_DO;
      C_DONT: cmd_state = ST_DONT;
      C_WILL: cmd_state = ST_WILL;
      C_WONT: cmd_state = ST_WONT;
      C_AYT:  begin cmd_push = 1'b1; cmd_kind = KIND_AYT; end
      C_EC:   begin cmd_push = 1'b1; cmd_val = BACKSPACE; end
      default: ;
    endcase

    is_echo  = (rx_byte == TELOPT_ECHO);
    is_sga   = (rx_byte == TELOPT_SGA);
    opt_flag = (is_echo & echo) | (is_sga & sga);

    state_next = state;
    echo_next  = echo;
    sga_next   = sga;
    push       = 1'b0;
    job        = '0;

    if (in_fire) begin
      if (session_reset) begin
        state_next = ST_CMD;
        echo_next  = 1'b0;
        sga_next   = 1'b0;
      end else begin
        unique case (state)
          ST_TYPE: begin
            state_next = cmd_state;
            push       = cmd_push;
            job.kind   = cmd_kind;
            job.val_a  = cmd_val;
          end
          ST_SBIAC: begin
            if (rx_byte == C_IAC) begin
              state_next = ST_SE;
            end else begin
              state_next = cmd_state;
              push       = cmd_push;
              job.kind   = cmd_kind;
              job.val_a  = cmd_val;
            end
          end
          ST_SBOPT: state_next = ST_SBVAL;
          ST_SBVAL: state_next = ST_SE;
          ST_SE: begin
            if (rx_byte == C_IAC) state_next = ST_SBIAC;
          end
          ST_DO, ST_WILL: begin
            state_next   = ST_CMD;
            job.is_reply = 1'b1;
            job.kind     = KIND_REPLY;
            job.val_b    = rx_byte;
            if (!is_echo && !is_sga) begin
              push      = 1'b1;
              job.val_a = (state == ST_DO) ? C_WONT : C_DONT;
            end else if (!opt_flag) begin
              push      = 1'b1;
              job.val_a = (state == ST_DO) ? C_WILL : C_DO;
              if (is_echo) echo_next = 1'b1;
              if (is_sga)  sga_next  = 1'b1;
            end
          end
          ST_DONT, ST_WONT: begin
            state_next   = ST_CMD;
            job.is_reply = 1'b1;
            job.kind     = KIND_REPLY;
            job.val_b    = rx_byte;
            job.val_a    = (state == ST_DONT) ? C_WONT : C_DONT;
            if (opt_flag) begin
              push = 1'b1;
              if (is_echo) echo_next = 1'b0;
              if (is_sga)  sga_next  = 1'b0;
            end
          end
          default: begin
            // normal mode, also any unused code
            if (rx_byte == C_IAC) begin
              state_next = ST_TYPE;
            end else begin
              state_next = ST_CMD;
              push       = 1'b1;
              job.val_a  = rx_byte;
            end
          end
        endcase
      end
    end

    job.echo = echo_next;
    job.sga  = sga_next;
  end

endmodule

// ===== src/telneg_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telneg_queue : small job FIFO between parser and reply sequencer
// Register-based ring with an occupancy count.
// ---------------------------------------------------------------------------
module telneg_queue
  import telneg_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic ready,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign ready      = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push & ready;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ready) else $error("job pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== src/telneg_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telneg_back : result sequencer with registered output stage
// Expands each job into one beat, or three beats for an IAC reply.
// ---------------------------------------------------------------------------
module telneg_back
  import telneg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_last,
  output logic       out_echo,
  output logic       out_sga
);

  logic [1:0] idx;        // beat index within a reply
  logic       load;
  logic       final_beat;
  logic [7:0] beat_value;

  assign load       = head_valid & (~out_valid | out_ready);
  assign final_beat = ~head_job.is_reply | (idx == 2'd2);
  assign pop        = load & final_beat;

  always_comb begin
    if (!head_job.is_reply) begin
      beat_value = head_job.val_a;
    end else begin
      case (idx)
        2'd0:    beat_value = C_IAC;
        2'd1:    beat_value = head_job.val_a;
        default: beat_value = head_job.val_b;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_beat ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= head_job.kind;
      out_value <= beat_value;
      out_last  <= final_beat;
      out_echo  <= head_job.echo;
      out_sga   <= head_job.sga;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd3) else $error("reply beat index out of range");

  a_idx_reply: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> (head_valid && head_job.is_reply))
    else $error("mid-reply without a reply job at queue head");

  a_notlast_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_kind == KIND_REPLY))
    else $error("non-final beat that is not a reply byte");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb : self-checking bench for telnet_rx_option_negotiator
// Streams directed and random Telnet byte sequences into the parser while
// both stream sides idle and stall at random. A behavioural copy of the
// parser and the option flags predicts every output beat. Each received beat
// is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
  import telneg_pkg::*;

  localparam logic [7:0] OPT_TTYPE = 8'd24;  // an option the block does not support
  localparam int         N_ITEMS   = 320;
  localparam int         QUIET_MAX = 2000;   // cycles with no beat on either side
  localparam int         TAIL      = 20;

  typedef struct {
    logic [7:0] rx_byte;
    logic       session_reset;
    bit         drain;      // hold-off marker: wait until every result is out
  } rx_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic       echo;
    logic       sga;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  rx_item_t     rx_items[$];
  out_beat_t    out_beats_due[$];
  out_beat_t    step_beats[$];
  rx_item_t     drive_item;
  out_beat_t    got;
  out_beat_t    want;
  parse_state_t rx_state = ST_CMD;
  logic         echo_opt = 1'b0;
  logic         sga_opt = 1'b0;
  int           n_items = 0;
  int           mismatches = 0;
  int           send_gap = 0;
  int           send_calm = 0;
  int           recv_stall = 0;
  int           recv_calm = 0;
  int           quiet = 0;

  telnet_rx_option_negotiator uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- behavioural parser --------------------------------------------------

  function automatic void emit(logic [1:0] kind, logic [7:0] value);
    step_beats.push_back('{kind, value, 1'b0, 1'b0, 1'b0});
  endfunction

  function automatic void emit_reply(logic [7:0] cmd, logic [7:0] opt);
    emit(KIND_REPLY, C_IAC);
    emit(KIND_REPLY, cmd);
    emit(KIND_REPLY, opt);
  endfunction

  // DO / WILL: set the flag and answer only on a change; refuse unknown options
  function automatic void option_on(logic [7:0] opt, logic [7:0] accept, logic [7:0] refuse);
    if (opt == TELOPT_ECHO) begin
      if (!echo_opt) begin
        echo_opt = 1'b1;
        emit_reply(accept, opt);
      end
    end else if (opt == TELOPT_SGA) begin
      if (!sga_opt) begin
        sga_opt = 1'b1;
        emit_reply(accept, opt);
      end
    end else begin
      emit_reply(refuse, opt);
    end
  endfunction

  // DONT / WONT: clear the flag, answer only on a change, ignore the rest
  function automatic void option_off(logic [7:0] opt, logic [7:0] answer);
    if (opt == TELOPT_ECHO && echo_opt) begin
      echo_opt = 1'b0;
      emit_reply(answer, opt);
    end else if (opt == TELOPT_SGA && sga_opt) begin
      sga_opt = 1'b0;
      emit_reply(answer, opt);
    end
  endfunction

  // byte following an IAC (also ends a subnegotiation on anything but IAC)
  function automatic void telnet_cmd(logic [7:0] b);
    rx_state = ST_CMD;
    case (b)
      C_IAC:  emit(KIND_DATA, C_IAC);
      C_SB:   rx_state = ST_SBOPT;
      C_DO:   rx_state = ST_DO;
      C_DONT: rx_state = ST_DONT;
      C_WILL: rx_state = ST_WILL;
      C_WONT: rx_state = ST_WONT;
      C_AYT:  emit(KIND_AYT, 8'd0);
      C_EC:   emit(KIND_DATA, BACKSPACE);
      default: ;
    endcase
  endfunction

  function automatic void predict_rx_byte(logic [7:0] b, logic session_reset);
    out_beat_t beat;
    step_beats.delete();
    if (session_reset) begin
      rx_state = ST_CMD;
      echo_opt = 1'b0;
      sga_opt  = 1'b0;
      return;
    end
    case (rx_state)
      ST_TYPE:  telnet_cmd(b);
      ST_SBIAC: begin
        if (b == C_IAC) rx_state = ST_SE;
        else telnet_cmd(b);
      end
      ST_SBOPT: rx_state = ST_SBVAL;
      ST_SBVAL: rx_state = ST_SE;
      ST_SE: begin
        if (b == C_IAC) rx_state = ST_SBIAC;
      end
      ST_DO: begin
        option_on(b, C_WILL, C_WONT);
        rx_state = ST_CMD;
      end
      ST_WILL: begin
        option_on(b, C_DO, C_DONT);
        rx_state = ST_CMD;
      end
      ST_DONT: begin
        option_off(b, C_WONT);
        rx_state = ST_CMD;
      end
      ST_WONT: begin
        option_off(b, C_DONT);
        rx_state = ST_CMD;
      end
      default: begin
        if (b == C_IAC) begin
          rx_state = ST_TYPE;
        end else begin
          rx_state = ST_CMD;
          emit(KIND_DATA, b);
        end
      end
    endcase
    // flags seen on every beat are those after the whole byte
    foreach (step_beats[i]) begin
      beat      = step_beats[i];
      beat.last = (i == step_beats.size() - 1);
      beat.echo = echo_opt;
      beat.sga  = sga_opt;
      out_beats_due.push_back(beat);
    end
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  function automatic void add_byte(logic [7:0] b, logic session_reset = 1'b0);
    rx_items.push_back('{b, session_reset, 1'b0});
    n_items++;
  endfunction

  function automatic void add_drain();
    rx_items.push_back('{8'd0, 1'b0, 1'b1});
  endfunction

  function automatic logic [7:0] plain_byte();
    return 8'($urandom_range(0, 254));
  endfunction

  // mostly back to back, some short pauses, a few long ones, calm stretches
  function automatic int pick_pause(inout int calm);
    int r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---- driver: one byte per beat off rx_items ------------------------------

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) predict_rx_byte(s_tdata, s_tuser);
      if (!s_tvalid || s_tready) begin
        // hold-off marker clears once every owed beat has been received
        if (rx_items.size() != 0 && rx_items[0].drain && out_beats_due.size() == 0)
          void'(rx_items.pop_front());
        if (send_gap != 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (rx_items.size() != 0 && !rx_items[0].drain) begin
          drive_item = rx_items.pop_front();
          s_tdata  <= drive_item.rx_byte;
          s_tuser  <= drive_item.session_reset;
          s_tvalid <= 1'b1;
          send_gap = pick_pause(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: random back-pressure and beat checks ------------------------

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tuser, m_tdata[7:0], m_tlast, m_tdata[8], m_tdata[9]};
        if (out_beats_due.size() == 0) begin
          $error("result beat with nothing expected: kind %0d value %0d", got.kind, got.value);
          mismatches++;
        end else begin
          want = out_beats_due.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
          end
          if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
          end
          if (got.echo !== want.echo) begin
            $error("echo_on: expected %0d, actual %0d", want.echo, got.echo);
            mismatches++;
          end
          if (got.sga !== want.sga) begin
            $error("suppress_ga_on: expected %0d, actual %0d", want.sga, got.sga);
            mismatches++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_stall = pick_pause(recv_calm);
      end
    end
  end

  // ---- watchdog: too long with no beat on either side -----------------------

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_MAX) begin
        $display("telnet_rx_option_negotiator regression: fail");
        $finish;
      end
    end
  end

  // ---- stimulus and end of run ----------------------------------------------

  initial begin
    int       pick;
    int       n;
    logic [7:0] opt;

    // directed: data extremes, escaped IAC then back to normal, EC, AYT
    add_byte(8'h00);
    add_byte(8'hFE);
    add_byte(C_IAC); add_byte(C_IAC); add_byte(8'h41);
    add_byte(C_IAC); add_byte(C_EC);
    add_byte(C_IAC); add_byte(C_AYT);
    // option changes in each direction, and refusal of an unknown option
    add_byte(C_IAC); add_byte(C_DO);   add_byte(TELOPT_ECHO);
    add_byte(C_IAC); add_byte(C_WILL); add_byte(TELOPT_SGA);
    add_byte(C_IAC); add_byte(C_DONT); add_byte(TELOPT_ECHO);
    add_byte(C_IAC); add_byte(C_WILL); add_byte(OPT_TTYPE);
    // new connection mid-stream: flags cleared, so WONT SUPGA gets no answer
    add_byte(C_IAC, 1'b1);
    add_byte(C_IAC); add_byte(C_WONT); add_byte(TELOPT_SGA);
    add_drain();

    // random: mostly well-formed sequences with random content, some noise
    while (n_items < N_ITEMS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0, 1, 2: begin
          n = $urandom_range(1, 4);
          repeat (n) add_byte(plain_byte());
        end
        3: begin
          add_byte(C_IAC); add_byte(C_IAC);
        end
        4, 5: begin
          add_byte(C_IAC);
          case ($urandom_range(0, 3))
            0:       add_byte(C_EC);
            1:       add_byte(C_AYT);
            2:       add_byte(C_SE);           // stray SE outside a subnegotiation
            default: add_byte(8'($urandom_range(0, 239)));
          endcase
        end
        6, 7, 8, 9, 10: begin
          add_byte(C_IAC);
          case ($urandom_range(0, 3))
            0:       add_byte(C_DO);
            1:       add_byte(C_DONT);
            2:       add_byte(C_WILL);
            default: add_byte(C_WONT);
          endcase
          if ($urandom_range(0, 9) < 7) opt = $urandom_range(0, 1) ? TELOPT_ECHO : TELOPT_SGA;
          else opt = 8'($urandom);
          add_byte(opt);
        end
        11, 12, 13: begin
          // subnegotiation: option, value, body with escaped IACs, then a close
          add_byte(C_IAC); add_byte(C_SB);
          add_byte(8'($urandom)); add_byte(8'($urandom));
          n = $urandom_range(0, 5);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
              add_byte(C_IAC); add_byte(C_IAC);
            end else begin
              add_byte(plain_byte());
            end
          end
          add_byte(C_IAC);
          case ($urandom_range(0, 5))
            0:       add_byte(C_DO);           // a command ends it early
            1:       add_byte(C_AYT);
            2:       add_byte(8'($urandom_range(0, 239)));
            default: add_byte(C_SE);
          endcase
        end
        14: add_byte(8'($urandom), 1'b1);
        15, 16, 17: begin
          n = $urandom_range(1, 3);
          repeat (n) add_byte(8'($urandom), $urandom_range(0, 29) == 0);
        end
        18: begin
          if ($urandom_range(0, 3) == 0) add_drain();
          else add_byte(plain_byte());
        end
        default: add_byte(C_IAC);              // lone IAC, the next byte is its command
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (rx_items.size() != 0 || s_tvalid || out_beats_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && out_beats_due.size() == 0) begin
      $display("telnet_rx_option_negotiator regression: pass");
    end else begin
      $display("telnet_rx_option_negotiator regression: fail");
    end
    $finish;
  end

endmodule
